// ----- rtl/core/first_fit_free_list_allocator_unit_macros.svh -----
// first_fit_free_list_allocator_unit_macros.svh
// assertion macros used by ffa_ctrl; expects clk_i and rst_ni in scope
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- rtl/core/ffa_pkg.sv -----
// ffa_pkg: shared types and constants of the first-fit allocator
// used by ffa_cell, ffa_ctrl and the top level
`default_nettype none
package ffa_pkg;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_MERGE,
    S_APPLY,
    S_DONE
  } state_e;

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } reg_idx_e;

  // control from the scan engine to every cell of the ring
  typedef struct packed {
    logic shift;
    logic init;
  } cell_ctl_t;

  localparam logic [31:0] RESET_BASE = 32'h0000_4000;
  localparam logic [32:0] RESET_SIZE = 33'h0_000F_C000;

endpackage
`default_nettype wire

// ----- rtl/core/ffa_cell.sv -----
// ffa_cell: one table entry (valid, base, size) of the rotating ring
// depends on ffa_pkg
`default_nettype none
module ffa_cell #(
  parameter int unsigned ADDR_BITS = 20,
  parameter bit          IS_HOME   = 1'b0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ffa_pkg::cell_ctl_t    ctl_i,
  input  wire                   nxt_valid_i,
  input  wire  [ADDR_BITS-1:0]  nxt_base_i,
  input  wire  [ADDR_BITS:0]    nxt_size_i,
  input  wire  [ADDR_BITS-1:0]  init_base_i,
  input  wire  [ADDR_BITS:0]    init_size_i,
  output logic                  valid_o,
  output logic [ADDR_BITS-1:0]  base_o,
  output logic [ADDR_BITS:0]    size_o
);
  import ffa_pkg::*;

  logic                 valid_q;
  logic [ADDR_BITS-1:0] base_q;
  logic [ADDR_BITS:0]   size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= IS_HOME;
    end else if (ctl_i.init) begin
      valid_q <= IS_HOME;
    end else if (ctl_i.shift) begin
      valid_q <= nxt_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RESET_BASE[ADDR_BITS-1:0];
      size_q <= RESET_SIZE[ADDR_BITS:0];
    end else if (ctl_i.init) begin
      base_q <= init_base_i;
      size_q <= init_size_i;
    end else if (ctl_i.shift) begin
      base_q <= nxt_base_i;
      size_q <= nxt_size_i;
    end
  end

  assign valid_o = valid_q;
  assign base_o  = base_q;
  assign size_o  = size_q;

endmodule
`default_nettype wire

// ----- rtl/core/ffa_ctrl.sv -----
// ffa_ctrl: scan engine that watches the head of the cell ring and rewrites entries
// depends on ffa_pkg and the allocator macro header
`default_nettype none
`include "first_fit_free_list_allocator_unit_macros.svh"
module ffa_ctrl #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned ADDR_BITS   = 20
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   req_valid_i,
  output logic                  req_ready_o,
  input  wire  [1:0]            req_func_i,
  input  wire  [ADDR_BITS-1:0]  req_addr_i,
  input  wire  [ADDR_BITS:0]    req_len_i,
  output logic                  rsp_valid_o,
  input  wire                   rsp_ready_i,
  output logic                  rsp_ok_o,
  output logic [ADDR_BITS-1:0]  rsp_grant_o,
  input  wire                   head_valid_i,
  input  wire  [ADDR_BITS-1:0]  head_base_i,
  input  wire  [ADDR_BITS:0]    head_size_i,
  output logic                  wb_valid_o,
  output logic [ADDR_BITS-1:0]  wb_base_o,
  output logic [ADDR_BITS:0]    wb_size_o,
  output ffa_pkg::cell_ctl_t    ctl_o
);
  import ffa_pkg::*;

  localparam int unsigned IDXW = $clog2(NUM_ENTRIES);
  localparam logic [IDXW-1:0] LAST = IDXW'(NUM_ENTRIES - 1);
  localparam logic [ADDR_BITS:0] SIZE_MAX = {(ADDR_BITS+1){1'b1}};

  state_e state_q, state_d;
  logic [IDXW-1:0]      cnt_q, cnt_d;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ADDR_BITS:0]   len_q;
  logic                 found_q, found_d;
  logic                 ok_q, ok_d;
  logic [ADDR_BITS-1:0] grant_q, grant_d;
  logic                 fhit_q, fhit_d, bhit_q, bhit_d;
  logic [IDXW-1:0]      fidx_q, fidx_d, bidx_q, bidx_d;
  logic [ADDR_BITS:0]   fsize_q, fsize_d, bsize_q, bsize_d;
  logic [ADDR_BITS:0]   merged_q, merged_d;
  logic                 out_valid_q, out_ok_q;
  logic [ADDR_BITS-1:0] out_grant_q;

  logic accept, last, busy_shift, buse, head_end_hit, head_start_hit, out_load;
  logic [ADDR_BITS+1:0] head_end, free_end;
  logic [ADDR_BITS+2:0] sum3;

  assign accept = req_valid_i && req_ready_o;
  assign last   = (cnt_q == LAST);
  // a zero-size entry can match both sides; then it only counts as front
  assign buse   = bhit_q && !(fhit_q && (fidx_q == bidx_q));

  assign head_end       = {1'b0, head_base_i} + {1'b0, head_size_i};
  assign free_end       = {2'b00, addr_q} + {1'b0, len_q};
  assign head_end_hit   = head_valid_i && (head_end == {2'b00, addr_q});
  assign head_start_hit = head_valid_i && ({2'b00, head_base_i} == free_end);
  assign sum3 = {2'b00, (fhit_q ? fsize_q : '0)} + {2'b00, (buse ? bsize_q : '0)}
              + {2'b00, len_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_e'(req_func_i))
            FN_ALLOC: state_d = S_ALLOC;
            FN_FREE:  state_d = S_SCAN;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_ALLOC: if (last) state_d = S_DONE;
      S_SCAN:  if (last) state_d = S_MERGE;
      S_MERGE: state_d = S_APPLY;
      S_APPLY: if (last) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || rsp_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy_shift = (state_q == S_ALLOC) || (state_q == S_SCAN) || (state_q == S_APPLY);
    req_ready_o = (state_q == S_IDLE);
    ctl_o.shift = busy_shift;
    ctl_o.init  = accept && (func_e'(req_func_i) == FN_INIT);
    out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_ready_i);

    wb_valid_o = head_valid_i;
    wb_base_o  = head_base_i;
    wb_size_o  = head_size_i;

    // the index follows the ring position, back to zero after a full pass
    cnt_d    = busy_shift ? (last ? '0 : cnt_q + 1'b1) : cnt_q;
    found_d  = found_q;
    ok_d     = ok_q;
    grant_d  = grant_q;
    fhit_d   = fhit_q;  fidx_d = fidx_q;  fsize_d = fsize_q;
    bhit_d   = bhit_q;  bidx_d = bidx_q;  bsize_d = bsize_q;
    merged_d = merged_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          found_d = 1'b0;
          grant_d = '0;
          fhit_d  = 1'b0;
          bhit_d  = 1'b0;
          ok_d    = (func_e'(req_func_i) == FN_INIT);
        end
      end
      S_ALLOC: begin
        if (!found_q && head_valid_i && (head_size_i >= len_q)) begin
          found_d = 1'b1;
          grant_d = head_base_i;
          if (head_size_i > len_q) begin
            wb_size_o = head_size_i - len_q;
            wb_base_o = head_base_i + len_q[ADDR_BITS-1:0];
          end else begin
            wb_valid_o = 1'b0;
          end
        end
        if (last) ok_d = found_d;
      end
      S_SCAN: begin
        if (!fhit_q && head_end_hit) begin
          fhit_d = 1'b1;  fidx_d = cnt_q;  fsize_d = head_size_i;
        end
        if (!bhit_q && head_start_hit) begin
          bhit_d = 1'b1;  bidx_d = cnt_q;  bsize_d = head_size_i;
        end
      end
      S_MERGE: begin
        merged_d = (sum3 > {2'b00, SIZE_MAX}) ? SIZE_MAX : sum3[ADDR_BITS:0];
      end
      S_APPLY: begin
        if (fhit_q && (cnt_q == fidx_q)) begin
          wb_size_o = merged_q;
        end
        if (buse && (cnt_q == bidx_q)) begin
          if (fhit_q) begin
            wb_valid_o = 1'b0;
          end else begin
            wb_base_o = addr_q;
            wb_size_o = merged_q;
          end
        end
        // no neighbor: take the lowest empty entry
        if (!fhit_q && !buse && !found_q && !head_valid_i) begin
          found_d    = 1'b1;
          wb_valid_o = 1'b1;
          wb_base_o  = addr_q;
          wb_size_o  = len_q;
        end
        if (last) ok_d = fhit_q || buse || found_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_addr_i;
      len_q  <= req_len_i;
    end
    found_q  <= found_d;
    ok_q     <= ok_d;
    grant_q  <= grant_d;
    fhit_q   <= fhit_d;  fidx_q <= fidx_d;  fsize_q <= fsize_d;
    bhit_q   <= bhit_d;  bidx_q <= bidx_d;  bsize_q <= bsize_d;
    merged_q <= merged_d;
    if (out_load) begin
      out_ok_q    <= ok_q;
      out_grant_q <= ok_q ? grant_q : '0;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_ok_o    = out_ok_q;
  assign rsp_grant_o = out_grant_q;

  `FFA_ASSERT_NXT(a_alloc_starts_at_zero, accept && (req_func_i == FN_ALLOC), (state_q == S_ALLOC) && (cnt_q == '0))
  `FFA_ASSERT_IMP(a_ring_home_at_merge, state_q == S_MERGE, cnt_q == '0)
  `FFA_ASSERT_IMP(a_fail_has_no_grant, out_valid_q && !out_ok_q, out_grant_q == '0)
  `FFA_ASSERT_NXT(a_result_held, out_valid_q && !rsp_ready_i, out_valid_q && $stable(out_grant_q))

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_free_list_allocator_unit.sv -----
// First-fit free-list allocator. The free-region table is a ring of NUM_ENTRIES cells that
// rotates by one entry per cycle past a single scan engine during each pass of an operation.
// Init and the unused operation code go from idle straight to the done state; allocate
// makes one pass; free makes a pass to find neighbors, a merge step and a pass to rewrite.
// The result then sits in an output register until taken, and a new request is accepted
// while it waits. Configuration writes take effect at the next init. No clearing pass.
// depends on ffa_pkg, ffa_cell and ffa_ctrl
`default_nettype none
module first_fit_free_list_allocator_unit #(
  parameter int unsigned NUM_ENTRIES = 64,
  parameter int unsigned ADDR_BITS   = 20
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_idx_i,
  input  wire  [ADDR_BITS:0]    cfg_wdata_i,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // func, address, length from bit 0 up, zero padded
  input  wire  [((2*ADDR_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // ok, granted_address from bit 0 up, zero padded
  output logic [((ADDR_BITS+1+7)/8)*8-1:0]   m_axis_tdata
);
  import ffa_pkg::*;

  localparam int unsigned OUT_W = ((ADDR_BITS+1+7)/8)*8;

  logic [ADDR_BITS-1:0] region_base_q;
  logic [ADDR_BITS:0]   region_size_q;

  logic                 cv [NUM_ENTRIES];
  logic [ADDR_BITS-1:0] cb [NUM_ENTRIES];
  logic [ADDR_BITS:0]   cs [NUM_ENTRIES];

  logic                 wb_valid, rsp_ok;
  logic [ADDR_BITS-1:0] wb_base, rsp_grant;
  logic [ADDR_BITS:0]   wb_size;
  cell_ctl_t            ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= RESET_BASE[ADDR_BITS-1:0];
      region_size_q <= RESET_SIZE[ADDR_BITS:0];
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BASE: region_base_q <= cfg_wdata_i[ADDR_BITS-1:0];
        REG_SIZE: region_size_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    if (k == NUM_ENTRIES - 1) begin : g_tail
      ffa_cell #(.ADDR_BITS(ADDR_BITS), .IS_HOME(k == 0)) u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl),
        .nxt_valid_i(wb_valid), .nxt_base_i(wb_base), .nxt_size_i(wb_size),
        .init_base_i(region_base_q), .init_size_i(region_size_q),
        .valid_o(cv[k]), .base_o(cb[k]), .size_o(cs[k])
      );
    end else begin : g_body
      ffa_cell #(.ADDR_BITS(ADDR_BITS), .IS_HOME(k == 0)) u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl),
        .nxt_valid_i(cv[k+1]), .nxt_base_i(cb[k+1]), .nxt_size_i(cs[k+1]),
        .init_base_i(region_base_q), .init_size_i(region_size_q),
        .valid_o(cv[k]), .base_o(cb[k]), .size_o(cs[k])
      );
    end
  end

  ffa_ctrl #(.NUM_ENTRIES(NUM_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_func_i(s_axis_tdata[1:0]),
    .req_addr_i(s_axis_tdata[ADDR_BITS+1:2]),
    .req_len_i(s_axis_tdata[2*ADDR_BITS+2:ADDR_BITS+2]),
    .rsp_valid_o(m_axis_tvalid),
    .rsp_ready_i(m_axis_tready),
    .rsp_ok_o(rsp_ok),
    .rsp_grant_o(rsp_grant),
    .head_valid_i(cv[0]),
    .head_base_i(cb[0]),
    .head_size_i(cs[0]),
    .wb_valid_o(wb_valid),
    .wb_base_o(wb_base),
    .wb_size_o(wb_size),
    .ctl_o(ctl)
  );

  assign m_axis_tdata = OUT_W'({rsp_grant, rsp_ok});

endmodule
`default_nettype wire

// ----- bench/ffa_scoreboard.sv -----
// ffa_scoreboard: watches the request and response streams of the allocator,
// predicts each response from its own copy of the free-region table and compares
// depends on ffa_pkg
module ffa_scoreboard (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [20:0] cfg_wdata_i,
  input  wire         req_valid_i,
  input  wire         req_ready_i,
  input  wire  [47:0] req_data_i,
  input  wire         rsp_valid_i,
  input  wire         rsp_ready_i,
  input  wire  [23:0] rsp_data_i,
  output int          errors_o,
  output int          pending_o
);
  import ffa_pkg::*;

  localparam int NE = 64;
  localparam logic [20:0] SIZE_MAX = 21'h1FFFFF;

  typedef struct packed {
    logic        ok;
    logic [19:0] grant;
  } grant_t;

  logic        free_vld[NE];
  logic [19:0] free_base[NE];
  logic [20:0] free_size[NE];
  logic [19:0] init_base;
  logic [20:0] init_size;
  grant_t      grants_q[$];

  function automatic logic [20:0] sat_add(input logic [22:0] v);
    return (v > 23'(SIZE_MAX)) ? SIZE_MAX : v[20:0];
  endfunction

  function automatic void reload_table();
    for (int k = 0; k < NE; k++) begin
      free_vld[k]  = 1'b0;
      free_base[k] = '0;
      free_size[k] = '0;
    end
    free_vld[0]  = 1'b1;
    free_base[0] = init_base;
    free_size[0] = init_size;
  endfunction

  function automatic grant_t predict_grant(input func_e f, input logic [19:0] a,
                                           input logic [20:0] l);
    grant_t r;
    int fr;
    int bk;
    r = '0;
    fr = -1;
    bk = -1;
    case (f)
      FN_INIT: begin
        reload_table();
        r.ok = 1'b1;
      end
      FN_ALLOC: begin
        for (int k = 0; k < NE; k++) begin
          if (free_vld[k] && free_size[k] >= l) begin
            r.ok = 1'b1;
            r.grant = free_base[k];
            if (free_size[k] > l) begin
              free_size[k] = free_size[k] - l;
              free_base[k] = free_base[k] + l[19:0];
            end else begin
              free_vld[k] = 1'b0;
            end
            break;
          end
        end
      end
      FN_FREE: begin
        for (int k = 0; k < NE; k++) begin
          if (free_vld[k]) begin
            if (fr < 0 && {2'b0, free_base[k]} + {1'b0, free_size[k]} == {2'b0, a}) fr = k;
            if (bk < 0 && {2'b0, free_base[k]} == {2'b0, a} + {1'b0, l}) bk = k;
          end
        end
        // a zero-sized entry can match on both sides, keep it as front only
        if (fr >= 0 && bk == fr) bk = -1;
        if (fr >= 0 && bk >= 0) begin
          free_size[fr] = sat_add(23'(free_size[fr]) + 23'(free_size[bk]) + 23'(l));
          free_vld[bk] = 1'b0;
          r.ok = 1'b1;
        end else if (bk >= 0) begin
          free_base[bk] = a;
          free_size[bk] = sat_add(23'(free_size[bk]) + 23'(l));
          r.ok = 1'b1;
        end else if (fr >= 0) begin
          free_size[fr] = sat_add(23'(free_size[fr]) + 23'(l));
          r.ok = 1'b1;
        end else begin
          for (int k = 0; k < NE; k++) begin
            if (!free_vld[k]) begin
              free_vld[k]  = 1'b1;
              free_base[k] = a;
              free_size[k] = l;
              r.ok = 1'b1;
              break;
            end
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = grants_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      init_base = RESET_BASE[19:0];
      init_size = RESET_SIZE[20:0];
      reload_table();
      grants_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_idx_i) == REG_BASE) init_base = cfg_wdata_i[19:0];
        else init_size = cfg_wdata_i;
      end
      if (req_valid_i && req_ready_i)
        grants_q.push_back(predict_grant(func_e'(req_data_i[1:0]), req_data_i[21:2],
                                         req_data_i[42:22]));
      if (rsp_valid_i && rsp_ready_i) begin
        got.ok = rsp_data_i[0];
        got.grant = rsp_data_i[20:1];
        if (grants_q.size() == 0) begin
          $display("%0t: response with none expected: ok=%0b grant=%h", $time, got.ok,
                   got.grant);
          errors_o++;
        end else begin
          want = grants_q.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
            errors_o++;
          end
          if (got.grant !== want.grant) begin
            $display("%0t: grant expected %h actual %h", $time, want.grant, got.grant);
            errors_o++;
          end
        end
      end
    end
  end
endmodule

// ----- bench/tb_first_fit_free_list_allocator_unit.sv -----
// tb_first_fit_free_list_allocator_unit: drives alloc, free, init and unused-code requests
// through several region settings; checking is done by ffa_scoreboard
// depends on ffa_pkg, ffa_scoreboard and the allocator rtl
module tb_first_fit_free_list_allocator_unit;
  import ffa_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [20:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  int          errors;
  int          pending;
  int          stall_cnt;
  bit          no_idle;

  typedef struct packed {
    logic [19:0] base;
    logic [20:0] len;
  } block_t;

  func_e       sent_func_q[$];
  logic [20:0] sent_len_q[$];
  block_t      held_q[$];

  first_fit_free_list_allocator_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  ffa_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready), .req_data_i(s_axis_tdata),
    .rsp_valid_i(m_axis_tvalid), .rsp_ready_i(m_axis_tready), .rsp_data_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // response side stalls
  always @(posedge clk_i) begin
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 5) == 0) stall_cnt <= pick_gap();
    end
  end

  // remember what was granted so frees can hand real blocks back
  always @(posedge clk_i) begin
    func_e       f;
    logic [20:0] l;
    if (m_axis_tvalid && m_axis_tready && sent_func_q.size() > 0) begin
      f = sent_func_q.pop_front();
      l = sent_len_q.pop_front();
      if (f == FN_INIT) held_q.delete();
      else if (f == FN_ALLOC && m_axis_tdata[0] && l != 0)
        held_q.push_back({m_axis_tdata[20:1], l});
    end
  end

  task automatic send(input func_e f, input logic [19:0] a, input logic [20:0] l);
    int gap;
    s_axis_tdata  <= {5'b0, l, a, f};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_func_q.push_back(f);
    sent_len_q.push_back(l);
    gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_region(input logic [19:0] b, input logic [20:0] sz);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_BASE;
    cfg_wdata_i <= {1'b0, b};
    @(posedge clk_i);
    cfg_idx_i   <= REG_SIZE;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send(FN_INIT, '0, '0);
  endtask

  task automatic random_item(input int maxlen);
    int     r;
    int     idx;
    block_t blk;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send(FN_ALLOC, 20'($urandom()), ($urandom_range(0, 19) == 0) ?
           21'($urandom_range(0, 21'h100000)) : 21'($urandom_range(0, maxlen)));
    end else if (r < 80 && held_q.size() > 0) begin
      idx = $urandom_range(0, held_q.size() - 1);
      blk = held_q[idx];
      held_q.delete(idx);
      send(FN_FREE, blk.base, blk.len);
    end else if (r < 93) begin
      send(FN_FREE, 20'($urandom()), ($urandom_range(0, 9) == 0) ?
           21'($urandom_range(0, 21'h100000)) : 21'($urandom_range(0, maxlen)));
    end else if (r < 98) begin
      send(FN_NONE, 20'($urandom()), 21'($urandom()));
    end else begin
      send(FN_INIT, 20'($urandom()), 21'($urandom()));
    end
  endtask

  initial begin
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_cnt     = 0;
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset region, then edge lengths and both-sided merge
    send(FN_ALLOC, '0, 21'h0);
    send(FN_ALLOC, '0, 21'h100000);
    send(FN_ALLOC, '0, 21'd16);
    send(FN_ALLOC, '0, 21'd16);
    send(FN_ALLOC, '0, 21'd16);
    send(FN_FREE, 20'h4010, 21'd16);
    send(FN_FREE, 20'h4030, 21'd16);
    send(FN_FREE, 20'h4020, 21'd16);
    send(FN_FREE, 20'h0, 21'h0);
    send(FN_FREE, 20'h0, 21'h0);
    send(FN_ALLOC, '0, 21'h0);
    send(FN_FREE, 20'hFFFFF, 21'h100000);
    send(FN_FREE, 20'hFFFFF, 21'h100000);
    send(FN_NONE, 20'hFFFFF, 21'h1FFFFF);
    send(FN_INIT, '0, '0);
    send(FN_ALLOC, '0, 21'hFC000);
    send(FN_ALLOC, '0, 21'h1);

    // base wraps on cut, the freed block merges as front neighbor
    set_region(20'hFFFFF, 21'h100000);
    send(FN_ALLOC, '0, 21'd2);
    send(FN_FREE, 20'hFFFFF, 21'd2);
    send(FN_FREE, 20'h0, 21'h100000);
    set_region(20'h0, 21'h0);
    send(FN_ALLOC, '0, 21'h0);
    send(FN_ALLOC, '0, 21'h0);

    // pause the sender until everything is back, then run without idling
    drain();
    no_idle = 1'b1;
    set_region(20'h0, 21'h100000);
    repeat (150) random_item(256);
    no_idle = 1'b0;

    set_region(20'h1000, 21'h800);
    repeat (400) random_item(64);
    set_region(20'($urandom()), 21'($urandom_range(0, 21'h100000)));
    repeat (300) random_item(4096);
    set_region(20'hFFF00, 21'h400);
    repeat (300) random_item(32);
    set_region(20'h4000, 21'hFC000);
    repeat (350) random_item(1024);

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** first_fit_free_list_allocator_unit: PASSED **");
    end else begin
      $display("** first_fit_free_list_allocator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("** first_fit_free_list_allocator_unit: FAILED **");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ffa_pkg.sv
rtl/core/ffa_cell.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_free_list_allocator_unit.sv
bench/ffa_scoreboard.sv
bench/tb_first_fit_free_list_allocator_unit.sv
